// ----- src/mavg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // window_length register
  localparam int             CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

  // control that travels with an item down the divider chain
  typedef struct packed {
    logic busy;
    logic neg;
    logic avg_valid;
  } div_ctl_t;

endpackage

`default_nettype wire

// ----- src/mavg_tap_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mavg_tap_cell
  import mavg_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TAP_INDEX    = 0
) (
  input  wire logic                    clk,
  input  wire logic                    shift,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic [CFG_W-1:0]        window_eff,
  output logic      [SAMPLE_WIDTH-1:0] sample_out,
  output logic      [SAMPLE_WIDTH-1:0] tap
);

  logic sel;

  // cell k holds the sample taken k+1 items ago
  always_ff @(posedge clk) begin
    if (shift) begin
      sample_out <= sample_in;
    end
  end

  assign sel = (32'(window_eff) == TAP_INDEX + 2);
  assign tap = sel ? sample_out : '0;

endmodule

`default_nettype wire

// ----- src/mavg_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mavg_div_cell
  import mavg_pkg::*;
#(
  parameter int SUM_W = SAMPLE_WIDTH_DEF + 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire div_ctl_t         ctl_in,
  input  wire logic [CFG_W-1:0] divisor_in,
  input  wire logic [CFG_W-1:0] rem_in,
  input  wire logic [SUM_W-1:0] dq_in,
  output div_ctl_t              ctl_out,
  output logic      [CFG_W-1:0] divisor_out,
  output logic      [CFG_W-1:0] rem_out,
  output logic      [SUM_W-1:0] dq_out
);

  logic [CFG_W:0]   trial;
  logic             ge;
  logic [CFG_W-1:0] rem_next;
  logic [SUM_W-1:0] dq_next;

  // one restoring step: bring down the top dividend bit, shift in the quotient bit
  always_comb begin
    trial    = {rem_in, dq_in[SUM_W-1]};
    ge       = (trial >= {1'b0, divisor_in});
    rem_next = ge ? CFG_W'(trial - {1'b0, divisor_in}) : trial[CFG_W-1:0];
    dq_next  = {dq_in[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divisor_out <= divisor_in;
      rem_out     <= rem_next;
      dq_out      <= dq_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/moving_average_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stages: front register (sum update), one divider cell per quotient bit, output register.
// Throughput: one item per cycle, divider chain included, while the output is not stalled.
// Reset (rst, synchronous, active high) clears the sum, the fill count, the valid flags
//   and sets window_length to 1. The sample delay line is not cleared.
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // config: window_length
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [CFG_W-1:0]                       cfg_data,
  // slave side; tdata: sample
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  wire logic                                   s_axis_tlast,
  // master side; tdata: average; tuser: average_valid
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  output logic      [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  output logic      [0:0]                             m_axis_tuser
);

  localparam int S_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int SUM_W    = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
  localparam int TAPS     = MAX_WINDOW - 1;
  localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(64'd1 << (SAMPLE_WIDTH - 1));
  localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                           en;
  logic                           accept;
  logic [CFG_W-1:0]               window_length;
  logic [CFG_W-1:0]               window_eff;
  logic signed [SUM_W-1:0]        running_sum;
  logic signed [SUM_W-1:0]        running_sum_next;
  logic [FILL_W-1:0]              fill_count;
  logic [FILL_W-1:0]              fill_count_next;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SUM_W-1:0]        total;
  logic signed [SAMPLE_WIDTH-1:0] oldest;
  logic [SAMPLE_WIDTH-1:0]        tap_any;
  logic                           active;

  logic [SAMPLE_WIDTH-1:0]        line  [TAPS];
  logic [SAMPLE_WIDTH-1:0]        taps  [TAPS];

  div_ctl_t                       front_ctl;
  logic [CFG_W-1:0]               front_div;
  logic [SUM_W-1:0]               front_mag;

  div_ctl_t                       ctl_chain [SUM_W+1];
  logic [CFG_W-1:0]               div_chain [SUM_W+1];
  logic [CFG_W-1:0]               rem_chain [SUM_W+1];
  logic [SUM_W-1:0]               dq_chain  [SUM_W+1];

  logic [SUM_W-1:0]               quot;
  logic [SAMPLE_WIDTH-1:0]        result;
  logic [SAMPLE_WIDTH-1:0]        out_avg;
  logic                           out_avg_valid;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_valid) begin
      window_length <= cfg_data;
    end
  end

  // zero counts as one, anything above MAX_WINDOW as MAX_WINDOW (the full line)
  always_comb begin
    if (window_length == '0) begin
      window_eff = CFG_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      window_eff = CFG_W'(MAX_WINDOW);
    end else begin
      window_eff = window_length;
    end
  end

  assign sample = s_axis_tdata[SAMPLE_WIDTH-1:0];

  // sample delay line
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    mavg_tap_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TAP_INDEX    (k)
    ) u_tap (
      .clk        (clk),
      .shift      (accept),
      .sample_in  ((k == 0) ? sample : line[(k == 0) ? 0 : k - 1]),
      .window_eff (window_eff),
      .sample_out (line[k]),
      .tap        (taps[k])
    );
  end

  always_comb begin
    tap_any = '0;
    for (int k = 0; k < TAPS; k++) begin
      tap_any = tap_any | taps[k];
    end
  end

  always_comb begin
    total  = running_sum + SUM_W'(sample);
    oldest = (window_eff == CFG_W'(1)) ? sample : tap_any;
    active = (32'(fill_count) + 32'd1) >= 32'(window_eff);
    if (s_axis_tlast) begin
      running_sum_next = '0;
      fill_count_next  = '0;
    end else begin
      running_sum_next = active ? total - SUM_W'(oldest) : total;
      fill_count_next  = (32'(fill_count) < MAX_WINDOW) ? fill_count + FILL_W'(1)
                                                        : fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      fill_count  <= '0;
      front_ctl   <= '0;
    end else if (en) begin
      front_ctl.busy <= accept;
      if (accept) begin
        running_sum         <= running_sum_next;
        fill_count          <= fill_count_next;
        front_ctl.neg       <= total[SUM_W-1];
        front_ctl.avg_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_div <= window_eff;
      front_mag <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
    end
  end

  assign ctl_chain[0] = front_ctl;
  assign div_chain[0] = front_div;
  assign rem_chain[0] = '0;
  assign dq_chain[0]  = front_mag;

  // divider: one cell per quotient bit
  for (genvar i = 0; i < SUM_W; i++) begin : g_div
    mavg_div_cell #(
      .SUM_W (SUM_W)
    ) u_div (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .ctl_in      (ctl_chain[i]),
      .divisor_in  (div_chain[i]),
      .rem_in      (rem_chain[i]),
      .dq_in       (dq_chain[i]),
      .ctl_out     (ctl_chain[i+1]),
      .divisor_out (div_chain[i+1]),
      .rem_out     (rem_chain[i+1]),
      .dq_out      (dq_chain[i+1])
    );
  end

  assign quot = dq_chain[SUM_W];

  // restore the sign and clamp to the sample range; zero while the window is filling
  always_comb begin
    if (!ctl_chain[SUM_W].avg_valid) begin
      result = '0;
    end else if (ctl_chain[SUM_W].neg) begin
      result = (quot > NEG_LIMIT) ? SAT_MIN : SAMPLE_WIDTH'(-quot);
    end else begin
      result = (quot > POS_LIMIT) ? SAT_MAX : quot[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= ctl_chain[SUM_W].busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_avg       <= result;
      out_avg_valid <= ctl_chain[SUM_W].avg_valid;
    end
  end

  assign m_axis_tdata = S_DATA_W'(out_avg);
  assign m_axis_tuser = out_avg_valid;

endmodule

`default_nettype wire

// ----- src/mavg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mavg_checker #(
  parameter int S_DATA_W = 16
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [S_DATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]          m_axis_tuser
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item present after reset");

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  // input is taken exactly when the output register can advance
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // while filling the average is zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("non-zero average while filling");

endmodule

bind moving_average_filter mavg_checker #(
  .S_DATA_W (((SAMPLE_WIDTH + 7) / 8) * 8)
) u_mavg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- bench/tb_moving_average_filter.sv -----
`timescale 1ns / 1ps

module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int MAXW      = MAX_WINDOW_DEF;
  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int TDW       = ((SW + 7) / 8) * 8;
  localparam int ACC_W     = SW + $clog2(MAXW);
  localparam int PTR_W     = $clog2(MAXW);
  localparam longint SMAX  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN  = -SMAX - 1;
  localparam int ITEMS     = 650;
  localparam int CALM_TAIL = 80;
  localparam int STUCK_MAX = 1000;

  typedef enum logic {FEED_SAMPLE, FEED_WINDOW} feed_kind_t;

  typedef struct {
    feed_kind_t       kind;
    logic [SW-1:0]    sample;
    logic             last;
    logic [CFG_W-1:0] window;
  } feed_t;

  typedef struct {
    logic [SW-1:0] average;
    logic          valid;
  } avg_res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [TDW-1:0]   s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [TDW-1:0]   m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  feed_t    feed_q[$];
  avg_res_t avg_due_q[$];

  // shadow of the filter state
  logic [CFG_W-1:0]       win_len = WINDOW_RESET;
  logic signed [SW-1:0]   hist [MAXW];
  logic [PTR_W-1:0]       hist_ptr = '0;
  logic signed [ACC_W-1:0] acc = '0;
  int                     seen = 0;

  logic s_took = 1'b0;
  logic cfg_took = 1'b0;
  int   s_gap = 0;
  int   m_stall = 0;
  int   faults = 0;
  int   stuck = 0;

  moving_average_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  function automatic avg_res_t advance_average(logic [SW-1:0] smp, logic lst);
    int w;
    logic signed [ACC_W-1:0] total;
    logic [PTR_W-1:0] old_idx;
    longint q;
    avg_res_t r;
    w = int'(win_len);
    if (w < 1) w = 1;
    if (w > MAXW) w = MAXW;
    hist[hist_ptr] = smp;
    total = acc + ACC_W'(signed'(smp));
    r.average = '0;
    r.valid = 1'b0;
    if (seen >= w - 1) begin
      q = longint'(total) / longint'(w);
      if (q > SMAX) q = SMAX;
      if (q < SMIN) q = SMIN;
      r.average = q[SW-1:0];
      r.valid = 1'b1;
      // drop the sample that leaves the window
      old_idx = PTR_W'(int'(hist_ptr) - w + 1);
      acc = total - ACC_W'(hist[old_idx]);
    end else begin
      acc = total;
    end
    if (seen < MAXW) seen++;
    hist_ptr++;
    if (lst) begin
      acc = '0;
      seen = 0;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($urandom_range(0, 31));
      3: return -SW'($urandom_range(0, 31));
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic add_sample(logic [SW-1:0] smp, logic lst);
    feed_t f;
    f.kind = FEED_SAMPLE;
    f.sample = smp;
    f.last = lst;
    f.window = '0;
    feed_q.push_back(f);
  endtask

  task automatic add_window(logic [CFG_W-1:0] w);
    feed_t f;
    f.kind = FEED_WINDOW;
    f.sample = '0;
    f.last = 1'b0;
    f.window = w;
    feed_q.push_back(f);
  endtask

  // driver: sender and receiver side
  always @(negedge clk) begin : drive
    feed_t f;
    logic nv, ncv, nrdy, calm;
    logic [SW-1:0] ndata;
    logic nlast;
    logic [CFG_W-1:0] ncfg;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      calm = feed_q.size() < CALM_TAIL;
      if (calm) begin
        s_gap = 0;
        m_stall = 0;
      end
      nv = s_axis_tvalid && !s_took;
      ncv = cfg_valid && !cfg_took;
      ndata = s_axis_tdata[SW-1:0];
      nlast = s_axis_tlast;
      ncfg = cfg_data;
      if (!nv && !ncv) begin
        if (s_gap > 0) begin
          s_gap--;
        end else if (feed_q.size() > 0) begin
          if (feed_q[0].kind == FEED_SAMPLE) begin
            f = feed_q.pop_front();
            nv = 1'b1;
            ndata = f.sample;
            nlast = f.last;
            if (!calm && $urandom_range(0, 6) == 0) s_gap = $urandom_range(1, 17);
          end else if (avg_due_q.size() == 0) begin
            // write the window only once the pipeline has drained
            f = feed_q.pop_front();
            ncv = 1'b1;
            ncfg = f.window;
          end
        end
      end
      if (m_stall > 0) begin
        m_stall--;
        nrdy = 1'b0;
      end else begin
        nrdy = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) m_stall = $urandom_range(1, 17);
      end
      s_axis_tvalid <= nv;
      s_axis_tdata <= TDW'(ndata);
      s_axis_tlast <= nlast;
      cfg_valid <= ncv;
      cfg_data <= ncfg;
      m_axis_tready <= nrdy;
    end
  end

  // monitor: predict on input, check on output
  always @(posedge clk) begin : watch
    avg_res_t want;
    s_took <= s_axis_tvalid && s_axis_tready && !rst;
    cfg_took <= cfg_valid && cfg_ready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) win_len = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        avg_due_q.push_back(advance_average(s_axis_tdata[SW-1:0], s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        if (avg_due_q.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected item: average %0d valid %b",
                     $signed(m_axis_tdata[SW-1:0]), m_axis_tuser[0]);
        end else begin
          want = avg_due_q.pop_front();
          if (m_axis_tdata[SW-1:0] !== want.average || m_axis_tuser[0] !== want.valid) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: expected average %0d valid %b, got average %0d valid %b",
                       $signed(want.average), want.valid,
                       $signed(m_axis_tdata[SW-1:0]), m_axis_tuser[0]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_MAX) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin : stimulus
    int count, w, weff, nblk, len, i;
    logic lst;

    // window of one after reset: extremes pass straight through
    add_sample(16'h7fff, 1'b0);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'hffff, 1'b1);
    // window of three: filling, negative truncation, block left open
    add_window(7'd3);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h8000, 1'b0);
    add_sample(16'h8001, 1'b0);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'h7fff, 1'b0);
    add_sample(16'h0001, 1'b0);
    // zero window mid-block: treated as one, stale sum saturates the average
    add_window(7'd0);
    add_sample(16'd5, 1'b0);
    add_sample(-16'sd5, 1'b1);
    // oversize window clamps to the maximum; stays filling
    add_window(7'd127);
    for (i = 0; i < 10; i++) add_sample(16'h7fff, i == 9);
    count = 22;

    while (count < ITEMS) begin
      case ($urandom_range(0, 15))
        0: w = 0;
        1: w = 127;
        2: w = MAXW;
        3: w = 1;
        4: w = $urandom_range(MAXW + 1, 126);
        5: w = $urandom_range(13, MAXW - 1);
        6: w = 2;
        default: w = $urandom_range(1, 12);
      endcase
      add_window(CFG_W'(w));
      weff = (w < 1) ? 1 : (w > MAXW) ? MAXW : w;
      nblk = (weff > 16) ? 1 : $urandom_range(1, 4);
      repeat (nblk) begin
        len = $urandom_range(1, weff + 16);
        for (i = 0; i < len; i++) begin
          // mostly whole blocks; now and then one cut short or left open
          if (i == len - 1) lst = ($urandom_range(0, 7) != 0);
          else lst = ($urandom_range(0, 39) == 0);
          add_sample(pick_sample(), lst);
        end
        count += len;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0 || s_axis_tvalid || cfg_valid || avg_due_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (faults == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mavg_pkg.sv
src/mavg_tap_cell.sv
src/mavg_div_cell.sv
src/moving_average_filter.sv
src/mavg_checker.sv
bench/tb_moving_average_filter.sv
